// ----- rtl/m2vfs_pkg.sv -----
`default_nettype none
package m2vfs_pkg;

  // Item function codes on the input channel.
  typedef enum logic [1:0] {
    FUNC_DATA    = 2'd0,
    FUNC_FLUSH   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  // Start codes that matter for frame splitting.
  localparam logic [31:0] CODE_SEQ = 32'h0000_01b3;
  localparam logic [31:0] CODE_GOP = 32'h0000_01b8;
  localparam logic [31:0] CODE_PIC = 32'h0000_0100;

  // Picture coding type sits in bits 5:3 of the second byte after the code.
  localparam logic [7:0] CODING_TYPE_MASK = 8'h38;
  localparam logic [7:0] CODING_TYPE_I    = 8'h08;

  // Window fill count saturates once four bytes are held.
  localparam logic [2:0] WINDOW_FULL = 3'd4;

  // Byte distance from a picture code to its coding type byte.
  localparam logic [1:0] CODING_TYPE_DIST = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/mpeg2_video_frame_splitter.sv -----
// MPEG-2 video elementary stream frame splitter.
// Input channel (in_valid, in_stall, in_func, in_data_byte): one word per cycle
// while in_stall is low. in_func selects a stream byte, an end-of-stream flush
// that emits the open frame with is_final set, or a restart that drops sync.
// Output channel (out_valid, out_stall, out_frame_length, out_frame_number,
// out_is_final): one word per completed frame. A frame closes when a
// sequence, GOP or picture start code follows a picture code in the frame;
// its length excludes the four bytes of the closing code.
// Timing: a word is registered on acceptance and evaluated against the
// byte window and frame state as it advances; its result is registered.
// Throughput is one input word per cycle while out_stall does not hold a
// pending result, set by the single evaluation stage between the input
// register and the output register.
// When out_stall holds a pending result, the evaluation stage waits and
// in_stall rises once the input register is also full; no word is lost.
// Reset (rst_n low, synchronous) clears sync, the frame state and the
// frame counter and empties both registers.
`default_nettype none
module mpeg2_video_frame_splitter #(
  parameter int FRAME_LENGTH_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [7:0]                   in_data_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [FRAME_LENGTH_BITS-1:0]      out_frame_length,
  output logic [31:0]                       out_frame_number,
  output logic                              out_is_final
);

  localparam int L = FRAME_LENGTH_BITS;
  localparam logic [L-1:0] LEN_MAX        = {L{1'b1}};
  localparam logic [L-1:0] LEN_CODE       = L'(4);
  localparam logic [L-1:0] LEN_PIC_SYNC   = L'(6);
  localparam logic [L-1:0] LEN_CODE_TRIM  = L'(3);

  // Input register.
  logic               in_valid_r, in_valid_nxt;
  m2vfs_pkg::func_t   in_func_r;
  logic [7:0]         in_byte_r;

  // Stream state.
  logic [31:0]  window_r, window_nxt;
  logic [2:0]   fill_r, fill_nxt;
  logic         synced_r, synced_nxt;
  logic [1:0]   ct_wait_r, ct_wait_nxt;
  logic         pic_seen_r, pic_seen_nxt;
  logic         open_r, open_nxt;
  logic [L-1:0] count_r, count_nxt;
  logic [31:0]  frame_cnt_r, frame_cnt_nxt;

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  logic [L-1:0] out_len_r;
  logic [31:0]  out_num_r;
  logic         out_final_r;

  // Stage control.
  logic         advance;
  logic         accept_in;
  logic         emit;
  logic         emit_final;
  logic [L-1:0] emit_len;

  // Evaluation scratch.
  logic [31:0]  win_shift;
  logic         is_code;
  logic [L-1:0] base_count;
  logic         base_pic;
  logic [L-1:0] count_inc;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_frame_length = out_len_r;
  assign out_frame_number = out_num_r;
  assign out_is_final     = out_final_r;

  // Input register control.
  always_comb begin
    if (accept_in) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  // Window shift and start code detection for the held byte.
  assign win_shift = {window_r[23:0], in_byte_r};
  assign is_code   = (fill_r >= 3'd3) &&
                     (win_shift == m2vfs_pkg::CODE_SEQ ||
                      win_shift == m2vfs_pkg::CODE_GOP ||
                      win_shift == m2vfs_pkg::CODE_PIC);

  // A synced byte after a flush opens a fresh frame.
  assign base_count = open_r ? count_r : '0;
  assign base_pic   = open_r ? pic_seen_r : 1'b0;
  assign count_inc  = (base_count == LEN_MAX) ? base_count : base_count + L'(1);

  // Frame tracking for one word.
  always_comb begin
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    synced_nxt    = synced_r;
    ct_wait_nxt   = ct_wait_r;
    pic_seen_nxt  = pic_seen_r;
    open_nxt      = open_r;
    count_nxt     = count_r;
    frame_cnt_nxt = frame_cnt_r;
    emit          = 1'b0;
    emit_final    = 1'b0;
    emit_len      = count_r;
    if (advance) begin
      unique case (in_func_r)
        m2vfs_pkg::FUNC_RESTART: begin
          window_nxt    = '0;
          fill_nxt      = '0;
          synced_nxt    = 1'b0;
          ct_wait_nxt   = '0;
          pic_seen_nxt  = 1'b0;
          open_nxt      = 1'b0;
          count_nxt     = '0;
          frame_cnt_nxt = '0;
        end
        m2vfs_pkg::FUNC_FLUSH: begin
          if (synced_r && open_r) begin
            emit          = 1'b1;
            emit_final    = 1'b1;
            emit_len      = count_r;
            frame_cnt_nxt = frame_cnt_r + 32'd1;
          end
          open_nxt     = 1'b0;
          count_nxt    = '0;
          pic_seen_nxt = 1'b0;
          ct_wait_nxt  = '0;
          window_nxt   = '0;
          fill_nxt     = '0;
        end
        m2vfs_pkg::FUNC_DATA: begin
          window_nxt = win_shift;
          if (fill_r < m2vfs_pkg::WINDOW_FULL) begin
            fill_nxt = fill_r + 3'd1;
          end
          if (!synced_r) begin
            // Searching for a sync point.
            if (ct_wait_r != 2'd0) begin
              ct_wait_nxt = ct_wait_r - 2'd1;
              if (ct_wait_r == 2'd1 &&
                  (in_byte_r & m2vfs_pkg::CODING_TYPE_MASK) == m2vfs_pkg::CODING_TYPE_I) begin
                synced_nxt   = 1'b1;
                open_nxt     = 1'b1;
                pic_seen_nxt = 1'b1;
                count_nxt    = LEN_PIC_SYNC;
              end
            end else if (is_code) begin
              if (win_shift == m2vfs_pkg::CODE_PIC) begin
                ct_wait_nxt = m2vfs_pkg::CODING_TYPE_DIST;
              end else begin
                synced_nxt   = 1'b1;
                open_nxt     = 1'b1;
                pic_seen_nxt = 1'b0;
                count_nxt    = LEN_CODE;
              end
            end
          end else begin
            // Collecting a frame.
            open_nxt     = 1'b1;
            count_nxt    = count_inc;
            pic_seen_nxt = base_pic;
            if (is_code) begin
              if (base_pic) begin
                emit          = 1'b1;
                frame_cnt_nxt = frame_cnt_r + 32'd1;
                if (base_count == LEN_MAX) begin
                  emit_len = LEN_MAX;
                end else if (base_count >= LEN_CODE_TRIM) begin
                  emit_len = base_count - LEN_CODE_TRIM;
                end else begin
                  emit_len = '0;
                end
                count_nxt    = LEN_CODE;
                pic_seen_nxt = (win_shift == m2vfs_pkg::CODE_PIC);
              end else if (win_shift == m2vfs_pkg::CODE_PIC) begin
                pic_seen_nxt = 1'b1;
              end
            end
          end
        end
        m2vfs_pkg::FUNC_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output register control.
  always_comb begin
    if (advance) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
      fill_r      <= '0;
      synced_r    <= 1'b0;
      ct_wait_r   <= '0;
      pic_seen_r  <= 1'b0;
      open_r      <= 1'b0;
      count_r     <= '0;
      frame_cnt_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      synced_r    <= synced_nxt;
      ct_wait_r   <= ct_wait_nxt;
      pic_seen_r  <= pic_seen_nxt;
      open_r      <= open_nxt;
      count_r     <= count_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_func_r <= m2vfs_pkg::func_t'(in_func);
      in_byte_r <= in_data_byte;
    end
    if (advance && emit) begin
      out_len_r   <= emit_len;
      out_num_r   <= frame_cnt_r;
      out_final_r <= emit_final;
    end
  end

  // Input backpressure only comes from a stalled pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // No frame is open while unsynced.
  a_open_synced: assert property (@(posedge clk) disable iff (!rst_n)
    !synced_r |-> !open_r)
    else $error("frame open while unsynced");

  // A picture can only be noted inside an open frame.
  a_pic_open: assert property (@(posedge clk) disable iff (!rst_n)
    pic_seen_r |-> open_r)
    else $error("picture seen with no open frame");

  // Window fill never exceeds four bytes.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= m2vfs_pkg::WINDOW_FULL)
    else $error("window fill out of range");

endmodule
`default_nettype wire
